/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, skipped while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked in every cycle, reset included.
`define ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/pres_pkg.sv */
`timescale 1ns / 1ps

package pres_pkg;

    localparam int VALUE_W         = 16;
    localparam int BUTTON_BYTE_W   = 8;
    localparam int KIND_W          = 3;
    localparam int NUM_MOTION      = 4;
    localparam int NUM_BUTTONS_DEF = 5;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [KIND_W-1:0] KIND_X      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_Y      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WHEEL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAN    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BUTTON = 3'd4;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [NUM_MOTION-1:0][VALUE_W-1:0] t_motion;

    localparam int MOTION_BITS = NUM_MOTION * VALUE_W;

    localparam logic [KIND_W-1:0] MOTION_KIND [NUM_MOTION] =
        '{KIND_X, KIND_Y, KIND_WHEEL, KIND_PAN};

endpackage

/* src/pres_queue.sv */
`timescale 1ns / 1ps

module pres_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_not_full,
    input  logic             i_pop,
    output logic             o_not_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_not_full  = (r_count != CW'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_data      = r_data[r_rptr];
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

/* src/pres_front.sv */
`timescale 1ns / 1ps

module pres_front #(
    parameter int NUM_BUTTONS = pres_pkg::NUM_BUTTONS_DEF,
    parameter int ENTRY_W     = pres_pkg::MOTION_BITS + 2 * NUM_BUTTONS + pres_pkg::NUM_MOTION
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  pres_pkg::t_value                  i_move_x,
    input  pres_pkg::t_value                  i_move_y,
    input  pres_pkg::t_value                  i_wheel_delta,
    input  pres_pkg::t_value                  i_pan_delta,
    input  logic [pres_pkg::BUTTON_BYTE_W-1:0] i_button_bits,
    output logic                              o_push,
    output logic [ENTRY_W-1:0]                o_entry,
    input  logic                              i_q_not_full
);
    import pres_pkg::*;

    localparam int MW = NUM_MOTION + NUM_BUTTONS;

    logic                   r_invert;
    logic [NUM_BUTTONS-1:0] r_held;
    logic [NUM_BUTTONS-1:0] buttons;
    logic [NUM_BUTTONS-1:0] changed;
    t_value                 wheel;
    t_motion                motion;
    logic [NUM_MOTION-1:0]  nonzero;
    logic [MW-1:0]          mask;
    logic                   accept;

    // Negate the wheel on request; the most negative value saturates.
    always_comb begin
        if (!r_invert) begin
            wheel = i_wheel_delta;
        end else if (i_wheel_delta == t_value'(16'h8000)) begin
            wheel = t_value'(16'h7FFF);
        end else begin
            wheel = -i_wheel_delta;
        end
    end

    always_comb begin
        motion[0] = i_move_x;
        motion[1] = i_move_y;
        motion[2] = wheel;
        motion[3] = i_pan_delta;
        for (int i = 0; i < NUM_MOTION; i++) begin
            nonzero[i] = (motion[i] != '0);
        end
    end

    assign buttons = i_button_bits[NUM_BUTTONS-1:0];
    assign changed = buttons ^ r_held;
    assign mask    = {changed, nonzero};
    assign o_ready = i_q_not_full;
    assign accept  = i_valid && o_ready;
    // Drop reports that cause no event.
    assign o_push  = accept && (mask != '0);
    assign o_entry = {mask, buttons, motion};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
            r_held   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_invert <= i_cfg_wdata;
            end
            if (accept) begin
                r_held <= buttons;
            end
        end
    end

endmodule

/* src/pres_back.sv */
`timescale 1ns / 1ps

module pres_back #(
    parameter int NUM_BUTTONS = pres_pkg::NUM_BUTTONS_DEF,
    parameter int ENTRY_W     = pres_pkg::MOTION_BITS + 2 * NUM_BUTTONS + pres_pkg::NUM_MOTION
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_not_empty,
    input  logic [ENTRY_W-1:0]         i_q_entry,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [pres_pkg::KIND_W-1:0] o_event_kind,
    output logic [pres_pkg::KIND_W-1:0] o_button_index,
    output pres_pkg::t_value           o_event_value,
    output logic                       o_last_event
);
    import pres_pkg::*;

    localparam int MW = NUM_MOTION + NUM_BUTTONS;
    localparam int PW = $clog2(MW);

    logic                   r_busy;
    logic [MW-1:0]          r_mask;
    logic [NUM_BUTTONS-1:0] r_buttons;
    t_motion                r_motion;
    logic                   r_out_valid;
    logic [KIND_W-1:0]      r_kind;
    logic [KIND_W-1:0]      r_index;
    t_value                 r_value;
    logic                   r_last;

    logic [MW-1:0]          sel;
    logic [MW-1:0]          rem;
    logic [PW-1:0]          pos;
    logic [PW-1:0]          bpos;
    logic [NUM_BUTTONS-1:0] bshift;
    logic                   advance;
    logic                   emit;
    logic                   take;
    logic [KIND_W-1:0]      n_kind;
    logic [KIND_W-1:0]      n_index;
    t_value                 n_value;

    assign sel     = r_mask & (~r_mask + 1'b1);
    assign rem     = r_mask & ~sel;
    assign advance = !r_out_valid || i_ready;
    assign emit    = r_busy && advance;
    // Load the next report when idle or when the current one sends its final event.
    assign take    = i_q_not_empty && (!r_busy || (emit && (rem == '0)));
    assign o_q_pop = take;

    always_comb begin
        pos = '0;
        for (int i = MW - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pos = PW'(i);
            end
        end
    end

    assign bpos   = pos - PW'(NUM_MOTION);
    assign bshift = r_buttons >> bpos;

    always_comb begin
        if (pos < PW'(NUM_MOTION)) begin
            n_kind  = MOTION_KIND[pos[1:0]];
            n_index = '0;
            n_value = r_motion[pos[1:0]];
        end else begin
            n_kind  = KIND_BUTTON;
            n_index = KIND_W'(bpos);
            n_value = VALUE_W'(bshift[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_mask <= rem;
                if (rem == '0) begin
                    r_busy <= 1'b0;
                end
            end
            if (take) begin
                r_busy <= 1'b1;
                r_mask <= i_q_entry[ENTRY_W-1 -: MW];
            end
            if (advance) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_buttons <= i_q_entry[MOTION_BITS +: NUM_BUTTONS];
            r_motion  <= i_q_entry[MOTION_BITS-1:0];
        end
        if (emit) begin
            r_kind  <= n_kind;
            r_index <= n_index;
            r_value <= n_value;
            r_last  <= (rem == '0);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_event_kind   = r_kind;
    assign o_button_index = r_index;
    assign o_event_value  = r_value;
    assign o_last_event   = r_last;

endmodule

/* src/pointer_report_event_serializer_unit.sv */
// The first event of a report passes through the report queue, the back's report registers
// and the output register before it shows on the outputs. Events leave one per cycle while
// the output is taken and events are pending; a report with N events leaves as a burst of N
// events, and a report that causes no event is dropped in its accept cycle. Reports are taken
// back to back while the two-entry report queue has room. Reset (synchronous, active low)
// clears the queue, the held buttons, the invert bit and the output valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pointer_report_event_serializer_unit #(
    parameter int NUM_BUTTONS = pres_pkg::NUM_BUTTONS_DEF,
    parameter int QUEUE_DEPTH = pres_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  pres_pkg::t_value                   i_move_x,
    input  pres_pkg::t_value                   i_move_y,
    input  pres_pkg::t_value                   i_wheel_delta,
    input  pres_pkg::t_value                   i_pan_delta,
    input  logic [pres_pkg::BUTTON_BYTE_W-1:0] i_button_bits,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [pres_pkg::KIND_W-1:0]        o_event_kind,
    output logic [pres_pkg::KIND_W-1:0]        o_button_index,
    output pres_pkg::t_value                   o_event_value,
    output logic                               o_last_event
);
    import pres_pkg::*;

    // One queued report: pending-event mask, new button state, four motion values.
    localparam int ENTRY_W = MOTION_BITS + 2 * NUM_BUTTONS + NUM_MOTION;

    logic               q_push;
    logic               q_pop;
    logic               q_not_full;
    logic               q_not_empty;
    logic [ENTRY_W-1:0] q_in;
    logic [ENTRY_W-1:0] q_out;

    // Front: apply wheel invert, compare buttons against the held state,
    // build the pending-event mask and push reports that cause events.
    pres_front #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_move_x      (i_move_x),
        .i_move_y      (i_move_y),
        .i_wheel_delta (i_wheel_delta),
        .i_pan_delta   (i_pan_delta),
        .i_button_bits (i_button_bits),
        .o_push        (q_push),
        .o_entry       (q_in),
        .i_q_not_full  (q_not_full)
    );

    // Queue: decouple report intake from event output.
    pres_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_data      (q_in),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_data      (q_out)
    );

    // Back: walk the pending mask lowest bit first, one event per cycle while the output is taken,
    // into the output register; flag the event that empties the mask.
    pres_back #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_not_empty  (q_not_empty),
        .i_q_entry      (q_out),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_kind   (o_event_kind),
        .o_button_index (o_button_index),
        .o_event_value  (o_event_value),
        .o_last_event   (o_last_event)
    );

    // A burst continues without a gap until its final event.
    `ASSERT_NXT(a_burst_no_gap, i_clk, i_rst_n, o_valid && i_ready && !o_last_event, o_valid)
    // Motion events carry a zero button index.
    `ASSERT_IMP(a_motion_index, i_clk, i_rst_n, o_valid && (o_event_kind != KIND_BUTTON),
                o_button_index == '0)
    // Button events carry only pressed or released.
    `ASSERT_IMP(a_button_value, i_clk, i_rst_n, o_valid && (o_event_kind == KIND_BUTTON),
                (o_event_value == t_value'(0)) || (o_event_value == t_value'(1)))
    // Nothing leaves the block in the cycle after reset.
    `ASSERT_ALW(a_reset_quiet, i_clk, !i_rst_n, !o_valid)

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

// Check the pointer report event serializer against a local predictor.
// Each accepted report is turned into the event burst that the block should
// emit. The burst is queued in order, and every accepted event is compared
// with the head of that queue. The run opens with directed reports: axis
// extremes, button edges, the inverted wheel and a disconnect release. Random
// phases follow, each setting the wheel invert bit and the idling pattern anew.
module tb_top;
    import pres_pkg::*;

    localparam int BUTTONS        = NUM_BUTTONS_DEF;
    localparam int SETTLE_CYCLES  = 6;       // lets in-flight reports clear the queue and output registers
    localparam int DRAIN_LIMIT    = 2000;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_REPORTS = 350;
    localparam int RANDOM_PHASES  = 5;
    localparam int MAX_REPORTED   = 10;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [KIND_W-1:0] index;
        t_value            value;
        logic              last;
    } pointer_event_t;

    // DUT inputs start at known values.
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic                     i_cfg_wdata   = 1'b0;
    logic                     i_valid       = 1'b0;
    t_value                   i_move_x      = '0;
    t_value                   i_move_y      = '0;
    t_value                   i_wheel_delta = '0;
    t_value                   i_pan_delta   = '0;
    logic [BUTTON_BYTE_W-1:0] i_button_bits = '0;
    logic                     i_ready       = 1'b0;

    logic                     o_ready;
    logic                     o_valid;
    logic [KIND_W-1:0]        o_event_kind;
    logic [KIND_W-1:0]        o_button_index;
    t_value                   o_event_value;
    logic                     o_last_event;

    // Predictor state: a mirror of the block's held buttons and invert bit.
    logic [BUTTONS-1:0] held_mirror    = '0;
    logic               invert_setting = 1'b0;

    // Events still owed by the block, oldest first.
    pointer_event_t pending_events[$];

    // Idling controls, changed between test phases.
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    int mismatches      = 0;
    int cycle_count     = 0;
    int reports_sent    = 0;
    int silent_reports  = 0;
    int events_checked  = 0;
    int button_events   = 0;
    int inverted_wheels = 0;

    pointer_event_t got_event;
    pointer_event_t want_event;

    pointer_report_event_serializer_unit #(
        .NUM_BUTTONS(BUTTONS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_move_x      (i_move_x),
        .i_move_y      (i_move_y),
        .i_wheel_delta (i_wheel_delta),
        .i_pan_delta   (i_pan_delta),
        .i_button_bits (i_button_bits),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_event_kind  (o_event_kind),
        .o_button_index(o_button_index),
        .o_event_value (o_event_value),
        .o_last_event  (o_last_event)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: watchdog expired after %0d cycles, %0d events still owed",
                     cycle_count, pending_events.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    // Build the event burst for one report: the nonzero motion values in axis
    // order, then one key event per changed low button in ascending order.
    // The held buttons advance only when the burst is not empty.
    task automatic predict_events(input t_value mx, input t_value my, input t_value wd,
                                  input t_value pd, input logic [BUTTON_BYTE_W-1:0] bb);
        t_value             motion [NUM_MOTION];
        logic [BUTTONS-1:0] now_pressed;
        logic [BUTTONS-1:0] toggled;
        pointer_event_t     ev;
        int                 total;
        int                 emitted;

        motion[0]   = mx;
        motion[1]   = my;
        motion[2]   = wd;
        motion[3]   = pd;
        now_pressed = bb[BUTTONS-1:0];
        toggled     = now_pressed ^ held_mirror;

        // Negate the wheel; the most negative value saturates instead of wrapping.
        if (invert_setting) begin
            motion[2] = (wd == 16'sh8000) ? 16'sh7fff : -wd;
        end

        total = 0;
        for (int a = 0; a < NUM_MOTION; a++) begin
            if (motion[a] != 0) total++;
        end
        for (int b = 0; b < BUTTONS; b++) begin
            if (toggled[b]) total++;
        end

        if (total == 0) begin
            silent_reports++;
            return;
        end

        emitted = 0;
        for (int a = 0; a < NUM_MOTION; a++) begin
            if (motion[a] != 0) begin
                emitted++;
                ev.kind  = MOTION_KIND[a];
                ev.index = '0;
                ev.value = motion[a];
                ev.last  = (emitted == total);
                pending_events.push_back(ev);
                if (a == 2 && invert_setting) inverted_wheels++;
            end
        end
        for (int b = 0; b < BUTTONS; b++) begin
            if (toggled[b]) begin
                emitted++;
                ev.kind  = KIND_BUTTON;
                ev.index = KIND_W'(b);
                ev.value = now_pressed[b] ? 16'sd1 : 16'sd0;
                ev.last  = (emitted == total);
                pending_events.push_back(ev);
                button_events++;
            end
        end
        held_mirror = now_pressed;
    endtask

    // Send one report. Called at a clock edge; returns at the edge that takes
    // it, with valid left high so that the next report can follow back to back.
    task automatic send_report(input t_value mx, input t_value my, input t_value wd,
                               input t_value pd, input logic [BUTTON_BYTE_W-1:0] bb);
        int gap;

        gap = tx_idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_move_x      <= mx;
        i_move_y      <= my;
        i_wheel_delta <= wd;
        i_pan_delta   <= pd;
        i_button_bits <= bb;
        i_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        predict_events(mx, my, wd, pd, bb);
        reports_sent++;
    endtask

    // Drop valid, let every owed event drain, then let the block settle
    // so that no report is still in flight.
    task automatic wait_idle();
        int waited;

        i_valid <= 1'b0;
        waited = 0;
        while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the wheel invert bit; only done with the block idle.
    task automatic set_wheel_invert(input logic value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        invert_setting = value;
    endtask

    // Receiver: hold ready low for a random stall before each event, then
    // keep it high until an event is taken.
    initial begin
        int stall;

        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = rx_idle_en ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // Event checker: compare every taken event with the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_event.kind  = o_event_kind;
            got_event.index = o_button_index;
            got_event.value = o_event_value;
            got_event.last  = o_last_event;
            if (pending_events.size() == 0) begin
                note_mismatch($sformatf("unexpected event kind=%0d index=%0d value=%0d last=%0b",
                                        got_event.kind, got_event.index,
                                        got_event.value, got_event.last));
            end else begin
                want_event = pending_events.pop_front();
                events_checked++;
                if (got_event.kind !== want_event.kind ||
                    got_event.index !== want_event.index ||
                    got_event.value !== want_event.value ||
                    got_event.last !== want_event.last) begin
                    note_mismatch($sformatf({"event %0d: expected kind=%0d index=%0d value=%0d ",
                                             "last=%0b, got kind=%0d index=%0d value=%0d last=%0b"},
                                            events_checked, want_event.kind, want_event.index,
                                            want_event.value, want_event.last, got_event.kind,
                                            got_event.index, got_event.value, got_event.last));
                end
            end
        end
    end

    // Pick a motion value: mostly zero or small, some full range, some extremes.
    function automatic t_value rand_motion();
        int pick;
        int small_step;

        pick = $urandom_range(0, 9);
        small_step = $urandom_range(0, 254);
        if (pick < 4) return '0;
        if (pick < 7) return t_value'(small_step - 127);
        if (pick < 9) return t_value'($urandom);
        return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endfunction

    // Each axis alone at both extremes, a mixed report, and an empty report.
    task automatic test_motion_extremes();
        set_wheel_invert(1'b0);
        send_report(16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00);
        send_report(16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00);
        send_report(16'sh0000, 16'sh7fff, 16'sh0000, 16'sh0000, 8'h00);
        send_report(16'sh0000, 16'sh8000, 16'sh0000, 16'sh0000, 8'h00);
        send_report(16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0000, 8'h00);
        send_report(16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000, 8'h00);
        send_report(16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff, 8'h00);
        send_report(16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 8'h00);
        send_report(-16'sd1, 16'sd1, -16'sd1, 16'sd1, 8'h00);
        send_report(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00);
    endtask

    // Press and release all buttons, upper bits that must be ignored,
    // and a full nine-event burst.
    task automatic test_buttons();
        send_report(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h1f);
        send_report(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'hff);
        send_report(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'he0);
        send_report(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h04);
        send_report(16'sd5, -16'sd5, 16'sd3, -16'sd3, 8'h1b);
    endtask

    // Inverted wheel: saturation of the most negative value, zero stays silent.
    task automatic test_wheel_invert();
        set_wheel_invert(1'b1);
        send_report(16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000, 8'h1b);
        send_report(16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0000, 8'h1b);
        send_report(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h1b);
        send_report(16'sh0000, 16'sh0000, 16'sd1, 16'sd7, 8'h1b);
        set_wheel_invert(1'b0);
    endtask

    // Disconnect: an all-zero report releases whatever is held.
    task automatic test_disconnect();
        send_report(16'sd3, 16'sd3, 16'sh0000, 16'sh0000, 8'h1b);
        send_report(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00);
    endtask

    // Random reports in phases. Each phase sets the invert bit and idling pattern
    // anew; one phase runs with no idling at all, and one pauses midway
    // until every owed event has come out.
    task automatic test_random_reports();
        logic [BUTTON_BYTE_W-1:0] buttons_now;
        int                       per_phase;

        buttons_now = '0;
        per_phase = RANDOM_REPORTS / RANDOM_PHASES;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_wheel_invert((p % 2) == 0);
            tx_idle_en = (p != 2);
            rx_idle_en = (p != 2) && (p != 3);
            for (int n = 0; n < per_phase; n++) begin
                if (p == 1 && n == per_phase / 2) wait_idle();
                // Mostly toggle one low button; sometimes replace the whole byte.
                case ($urandom_range(0, 9))
                    7, 8:    buttons_now = BUTTON_BYTE_W'($urandom);
                    9:       buttons_now = '0;
                    default: buttons_now[$urandom_range(0, BUTTONS - 1)] ^= 1'b1;
                endcase
                send_report(rand_motion(), rand_motion(), rand_motion(), rand_motion(),
                            buttons_now);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_motion_extremes();
        test_buttons();
        test_wheel_invert();
        test_disconnect();
        test_random_reports();

        wait_idle();
        if (pending_events.size() != 0) begin
            note_mismatch($sformatf("%0d events never came out", pending_events.size()));
        end

        $display("tb_top: %0d reports sent, %0d of them silent; %0d events checked",
                 reports_sent, silent_reports, events_checked);
        $display("tb_top: %0d button events, %0d inverted wheel events, %0d mismatches",
                 button_events, inverted_wheels, mismatches);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/pres_pkg.sv
src/pres_queue.sv
src/pres_front.sv
src/pres_back.sv
src/pointer_report_event_serializer_unit.sv
sim/tb_top.sv
